>>> sv/aggp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the antialiased glyph pixel plotter.
// No dependencies; every other file refers to this package by scoped names.
package aggp_pkg;

    localparam int COORD_W     = 12;
    localparam int SHADE_W     = 4;
    localparam int BYTE_ADDR_W = 18;
    localparam int POS_W       = 24;

    // operation codes
    localparam logic OP_PLOT = 1'b0;
    localparam logic OP_READ = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_ROTATE = 1'b0;
    localparam logic REG_PAPER  = 1'b1;

    localparam logic               ROTATE_RESET = 1'b1;
    localparam logic [SHADE_W-1:0] PAPER_RESET  = 4'hF;

    localparam logic [7:0] CLEAR_BYTE = 8'hFF;
    localparam logic [7:0] LO_MASK    = 8'h0F;
    localparam logic [7:0] HI_MASK    = 8'hF0;

    // x/15 for 0 <= x <= 225 equals (x*137) >> 11
    localparam logic [7:0] BLEND_RECIP = 8'd137;
    localparam int         BLEND_SHIFT = 11;

    // result queue
    localparam int          OQ_DEPTH = 8;
    localparam int          OQ_PTR_W = 3;
    localparam int          OQ_CNT_W = 4;
    localparam logic [OQ_CNT_W-1:0] OQ_FULL = 4'd8;

    typedef struct packed {
        logic                          operation;
        logic signed [COORD_W-1:0]     x_coord;
        logic signed [COORD_W-1:0]     y_coord;
        logic [SHADE_W-1:0]            coverage;
        logic [SHADE_W-1:0]            ink;
        logic [BYTE_ADDR_W-1:0]        byte_address;
    } plot_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       pixel_written;
    } plot_result_t;

endpackage

>>> sv/aggp_frame_mem.sv
`timescale 1ns / 1ps
// Packed 4bpp frame store: one write port, one registered read port.
// Runs a clearing pass to paper white after reset. Uses aggp_pkg.
module aggp_frame_mem #(
    parameter int DEPTH  = 259200,
    parameter int ADDR_W = 18
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] rd_idx,
    output logic [7:0]        rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_idx,
    input  logic [7:0]        wr_data,
    output logic              clearing
);

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);

    logic [7:0]        frame_mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic              clearing_reg;
    logic              clearing_next;
    logic [ADDR_W-1:0] clr_idx_reg;
    logic [ADDR_W-1:0] clr_idx_next;
    logic              we;
    logic [ADDR_W-1:0] widx;
    logic [7:0]        wdata;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == LAST_IDX)
            begin
                clearing_next = 1'b0;
            end
        end
        we    = clearing_reg | wr_en;
        widx  = clearing_reg ? clr_idx_reg : wr_idx;
        wdata = clearing_reg ? aggp_pkg::CLEAR_BYTE : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            frame_mem[widx] <= wdata;
        end
        rd_data_reg <= frame_mem[rd_idx];
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

>>> sv/aggp_plot_pipe.sv
`timescale 1ns / 1ps
// Three-stage plot pipeline: rotate and blend, address and read, merge and write back.
// Forwards the last written byte into a read of the same entry. Uses aggp_pkg.
module aggp_plot_pipe #(
    parameter int PANEL_WIDTH  = 960,
    parameter int PANEL_HEIGHT = 540,
    parameter int ADDR_W       = 18
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  aggp_pkg::plot_item_t          item,
    input  logic                          rotate_ccw,
    input  logic [aggp_pkg::SHADE_W-1:0]  paper_shade,
    output logic [ADDR_W-1:0]             rd_idx,
    input  logic [7:0]                    rd_data,
    output logic                          wr_en,
    output logic [ADDR_W-1:0]             wr_idx,
    output logic [7:0]                    wr_data,
    output logic                          push,
    output aggp_pkg::plot_result_t        result
);

    localparam int ROW_BYTES   = PANEL_WIDTH / 2;
    localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam int PW          = aggp_pkg::POS_W;

    localparam logic [12:0]   CANVAS_COLS = 13'(PANEL_HEIGHT);
    localparam logic [12:0]   CANVAS_ROWS = 13'(PANEL_WIDTH);
    localparam logic [12:0]   COL_LAST    = 13'(PANEL_HEIGHT - 1);
    localparam logic [12:0]   ROW_LAST    = 13'(PANEL_WIDTH - 1);
    localparam logic [PW-1:0] ROW_STEP    = PW'(ROW_BYTES);
    localparam logic [PW-1:0] STORE_LIMIT = PW'(STORE_BYTES);

    // stage 1: registered item
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    aggp_pkg::plot_item_t s1_item_reg;
    aggp_pkg::plot_item_t s1_item_next;

    logic [12:0]          xu;
    logic [12:0]          yu;
    logic                 on_canvas;
    logic [12:0]          px13;
    logic [12:0]          py13;
    logic signed [4:0]    diff;
    logic signed [9:0]    blend_full;

    // stage 2
    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    logic                 s2_op_reg;
    logic                 s2_op_next;
    logic                 s2_plot_reg;
    logic                 s2_plot_next;
    logic [PW-1:0]        s2_row_reg;
    logic [PW-1:0]        s2_row_next;
    logic [10:0]          s2_half_reg;
    logic [10:0]          s2_half_next;
    logic                 s2_hi_reg;
    logic                 s2_hi_next;
    logic signed [8:0]    s2_blend_reg;
    logic signed [8:0]    s2_blend_next;
    logic [aggp_pkg::BYTE_ADDR_W-1:0] s2_addr_reg;
    logic [aggp_pkg::BYTE_ADDR_W-1:0] s2_addr_next;

    logic [PW-1:0]        pos;
    logic                 in_range;
    logic [7:0]           mag;
    logic [15:0]          recip_prod;
    logic [3:0]           quot;
    logic [3:0]           shade;

    // stage 3
    logic                 s3_valid_reg;
    logic                 s3_valid_next;
    logic                 s3_op_reg;
    logic                 s3_op_next;
    logic                 s3_hit_reg;
    logic                 s3_hit_next;
    logic                 s3_wr_reg;
    logic                 s3_wr_next;
    logic [ADDR_W-1:0]    s3_idx_reg;
    logic [ADDR_W-1:0]    s3_idx_next;
    logic                 s3_hi_reg;
    logic                 s3_hi_next;
    logic [3:0]           s3_shade_reg;
    logic [3:0]           s3_shade_next;
    logic                 s3_fwd_reg;
    logic                 s3_fwd_next;
    logic [7:0]           s3_fwd_data_reg;
    logic [7:0]           s3_fwd_data_next;

    logic [7:0]           old_byte;
    logic [7:0]           new_byte;

    // stage 1: bounds, rotation, blend product, row offset
    always_comb
    begin
        s1_valid_next = take;
        s1_item_next  = item;

        xu        = {1'b0, s1_item_reg.x_coord};
        yu        = {1'b0, s1_item_reg.y_coord};
        on_canvas = !s1_item_reg.x_coord[11] && !s1_item_reg.y_coord[11]
                    && (xu < CANVAS_COLS) && (yu < CANVAS_ROWS);

        if (rotate_ccw)
        begin
            px13 = yu;
            py13 = COL_LAST - xu;
        end
        else
        begin
            px13 = ROW_LAST - yu;
            py13 = xu;
        end

        diff       = $signed({1'b0, s1_item_reg.ink}) - $signed({1'b0, paper_shade});
        blend_full = $signed({1'b0, s1_item_reg.coverage}) * diff;

        s2_valid_next = s1_valid_reg;
        s2_op_next    = s1_item_reg.operation;
        s2_plot_next  = (s1_item_reg.operation == aggp_pkg::OP_PLOT)
                        && (s1_item_reg.coverage != '0) && on_canvas;
        s2_row_next   = PW'(py13[11:0]) * ROW_STEP;
        s2_half_next  = px13[11:1];
        s2_hi_next    = px13[0];
        s2_blend_next = blend_full[8:0];
        s2_addr_next  = s1_item_reg.byte_address;
    end

    // stage 2: byte address, range check, shade quotient
    always_comb
    begin
        if (s2_op_reg == aggp_pkg::OP_READ)
        begin
            pos = PW'(s2_addr_reg);
        end
        else
        begin
            pos = s2_row_reg + PW'(s2_half_reg);
        end
        in_range = pos < STORE_LIMIT;
        rd_idx   = pos[ADDR_W-1:0];

        // truncate toward zero: divide the magnitude, then restore the sign
        mag        = s2_blend_reg[8] ? 8'(-s2_blend_reg) : 8'(s2_blend_reg);
        recip_prod = {8'b0, mag} * {8'b0, aggp_pkg::BLEND_RECIP};
        quot       = recip_prod[aggp_pkg::BLEND_SHIFT +: 4];
        shade      = s2_blend_reg[8] ? (paper_shade - quot) : (paper_shade + quot);

        s3_valid_next = s2_valid_reg;
        s3_op_next    = s2_op_reg;
        s3_hit_next   = in_range;
        s3_wr_next    = s2_plot_reg && in_range;
        s3_idx_next   = pos[ADDR_W-1:0];
        s3_hi_next    = s2_hi_reg;
        s3_shade_next = shade;

        // the byte written this cycle is not yet in the read data
        s3_fwd_next      = s3_valid_reg && s3_wr_reg && (s3_idx_reg == pos[ADDR_W-1:0]);
        s3_fwd_data_next = new_byte;
    end

    // stage 3: merge nibble, write back, form result
    always_comb
    begin
        old_byte = s3_fwd_reg ? s3_fwd_data_reg : rd_data;
        if (s3_hi_reg)
        begin
            new_byte = (old_byte & aggp_pkg::LO_MASK) | {s3_shade_reg, 4'b0};
        end
        else
        begin
            new_byte = (old_byte & aggp_pkg::HI_MASK) | {4'b0, s3_shade_reg};
        end

        wr_en   = s3_valid_reg && s3_wr_reg;
        wr_idx  = s3_idx_reg;
        wr_data = new_byte;

        push                 = s3_valid_reg;
        result.read_byte     = ((s3_op_reg == aggp_pkg::OP_READ) && s3_hit_reg) ? old_byte : 8'h00;
        result.pixel_written = (s3_op_reg == aggp_pkg::OP_PLOT) && s3_wr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg <= s1_item_next;
        end
        s2_op_reg       <= s2_op_next;
        s2_plot_reg     <= s2_plot_next;
        s2_row_reg      <= s2_row_next;
        s2_half_reg     <= s2_half_next;
        s2_hi_reg       <= s2_hi_next;
        s2_blend_reg    <= s2_blend_next;
        s2_addr_reg     <= s2_addr_next;
        s3_op_reg       <= s3_op_next;
        s3_hit_reg      <= s3_hit_next;
        s3_wr_reg       <= s3_wr_next;
        s3_idx_reg      <= s3_idx_next;
        s3_hi_reg       <= s3_hi_next;
        s3_shade_reg    <= s3_shade_next;
        s3_fwd_reg      <= s3_fwd_next;
        s3_fwd_data_reg <= s3_fwd_data_next;
    end

endmodule

>>> sv/aggp_result_q.sv
`timescale 1ns / 1ps
// Result queue with a credit count of beats accepted but not yet delivered.
// Keeps the pipeline free of stalls. Uses aggp_pkg.
module aggp_result_q (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic                   push,
    input  aggp_pkg::plot_result_t push_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output aggp_pkg::plot_result_t out_data,
    output logic                   has_room
);

    aggp_pkg::plot_result_t q_mem [aggp_pkg::OQ_DEPTH];

    logic [aggp_pkg::OQ_PTR_W-1:0] wr_ptr_reg;
    logic [aggp_pkg::OQ_PTR_W-1:0] wr_ptr_next;
    logic [aggp_pkg::OQ_PTR_W-1:0] rd_ptr_reg;
    logic [aggp_pkg::OQ_PTR_W-1:0] rd_ptr_next;
    logic [aggp_pkg::OQ_CNT_W-1:0] fill_reg;
    logic [aggp_pkg::OQ_CNT_W-1:0] fill_next;
    logic [aggp_pkg::OQ_CNT_W-1:0] credit_reg;
    logic [aggp_pkg::OQ_CNT_W-1:0] credit_next;
    logic                          pop;

    always_comb
    begin
        pop         = (fill_reg != '0) && out_ready;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + {3'b0, push} - {3'b0, pop};
        credit_next = credit_reg + {3'b0, take} - {3'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = fill_reg != '0;
    assign out_data  = q_mem[rd_ptr_reg];
    assign has_room  = credit_reg < aggp_pkg::OQ_FULL;

endmodule

>>> sv/antialiased_glyph_pixel_plotter_top.sv
`timescale 1ns / 1ps
// Top level of the antialiased glyph pixel plotter: APB registers, plot pipeline,
// frame store and result queue. Uses aggp_pkg and all aggp_* modules but aggp_checker.
//
// Input channel (in_valid/in_ready) carries one beat per pixel plot or byte read.
// A plot blends ink toward paper by coverage, rotates the portrait coordinate onto
// the landscape panel and rewrites one nibble of the packed 4bpp store; a read
// returns one store byte. Output channel (out_valid/out_ready) returns exactly one
// beat per input beat, in order.
// Throughput is one beat per cycle while in_ready is high: the store is read,
// merged and written back in a three-stage pipeline, and a byte being written back
// is forwarded into a read of the same byte, as the store's read port is registered.
// An accepted beat is registered into stage 1, passes through stages 2 and 3 and is
// then written into the result queue, which raises out_valid.
// The receiver may stall at will: results wait in an 8-entry queue, and in_ready
// drops once 8 beats are accepted but not delivered.
// Reset sets the registers (rotate_ccw=1, paper_shade=15) and starts a clearing
// pass that writes 0xFF to every one of the (PANEL_WIDTH/2)*PANEL_HEIGHT store bytes
// (259200 at the defaults), one byte a cycle; in_ready stays low during the pass,
// while register writes are taken as usual.
module antialiased_glyph_pixel_plotter_top #(
    parameter int PANEL_WIDTH  = 960,
    parameter int PANEL_HEIGHT = 540
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic signed [11:0] x_coord,
    input  logic signed [11:0] y_coord,
    input  logic [3:0]  coverage,
    input  logic [3:0]  ink,
    input  logic [17:0] byte_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_byte,
    output logic        pixel_written
);

    localparam int STORE_BYTES = (PANEL_WIDTH / 2) * PANEL_HEIGHT;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    logic       rotate_ccw_reg;
    logic       rotate_ccw_next;
    logic [3:0] paper_shade_reg;
    logic [3:0] paper_shade_next;
    logic       cfg_write;

    logic                   take;
    logic                   clearing;
    logic                   has_room;
    aggp_pkg::plot_item_t   item;
    logic [ADDR_W-1:0]      rd_idx;
    logic [7:0]             rd_data;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_idx;
    logic [7:0]             wr_data;
    logic                   push;
    aggp_pkg::plot_result_t push_data;
    aggp_pkg::plot_result_t out_data;

    // register file
    always_comb
    begin
        cfg_write        = psel && penable && pwrite;
        rotate_ccw_next  = rotate_ccw_reg;
        paper_shade_next = paper_shade_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                aggp_pkg::REG_ROTATE: rotate_ccw_next  = pwdata[0];
                aggp_pkg::REG_PAPER:  paper_shade_next = pwdata[3:0];
                default: ;
            endcase
        end
        case (paddr[2])
            aggp_pkg::REG_ROTATE: prdata = {31'b0, rotate_ccw_reg};
            aggp_pkg::REG_PAPER:  prdata = {28'b0, paper_shade_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotate_ccw_reg  <= aggp_pkg::ROTATE_RESET;
            paper_shade_reg <= aggp_pkg::PAPER_RESET;
        end
        else
        begin
            rotate_ccw_reg  <= rotate_ccw_next;
            paper_shade_reg <= paper_shade_next;
        end
    end

    assign pready = 1'b1;

    assign in_ready = !clearing && has_room;
    assign take     = in_valid && in_ready;

    assign item.operation    = operation;
    assign item.x_coord      = x_coord;
    assign item.y_coord      = y_coord;
    assign item.coverage     = coverage;
    assign item.ink          = ink;
    assign item.byte_address = byte_address;

    aggp_plot_pipe #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .item        (item),
        .rotate_ccw  (rotate_ccw_reg),
        .paper_shade (paper_shade_reg),
        .rd_idx      (rd_idx),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_idx      (wr_idx),
        .wr_data     (wr_data),
        .push        (push),
        .result      (push_data)
    );

    aggp_frame_mem #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (rd_idx),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_data  (wr_data),
        .clearing (clearing)
    );

    aggp_result_q u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .push      (push),
        .push_data (push_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .has_room  (has_room)
    );

    assign read_byte     = out_data.read_byte;
    assign pixel_written = out_data.pixel_written;

endmodule

>>> sv/aggp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the antialiased glyph pixel plotter, bound to the top level.
// Tracks beats in flight from the ports alone. Uses aggp_pkg.
module aggp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_byte,
    input logic       pixel_written
);

    logic [7:0] pend_reg;
    logic [7:0] pend_next;
    logic       in_beat;
    logic       out_beat;

    always_comb
    begin
        in_beat   = in_valid && in_ready;
        out_beat  = out_valid && out_ready;
        pend_next = pend_reg + {7'b0, in_beat} - {7'b0, out_beat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a result only follows an accepted item
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 8'd0)
        else $error("result beat with no item outstanding");

    // an item is accepted only while fewer beats than the queue depth are outstanding
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |-> pend_reg < 8'(aggp_pkg::OQ_DEPTH))
        else $error("item accepted beyond queue depth");

    // a result is either a read byte or a write flag, never both
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pixel_written) |-> read_byte == 8'h00)
        else $error("plot result carries read data");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(read_byte) && $stable(pixel_written))
        else $error("stalled result beat changed");

endmodule

bind antialiased_glyph_pixel_plotter_top aggp_checker u_aggp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_byte     (read_byte),
    .pixel_written (pixel_written)
);
